/* hw/rtl/rti_pkg.sv */
// shared types and constants for the ray / triangle intersection block
package rti_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIFO_DEPTH      = 4;
  localparam int NORM_W          = 15;

  localparam logic              REQ_LOAD     = 1'b0;
  localparam logic              REQ_RAY      = 1'b1;
  localparam logic [15:0]       TOL_RESET    = 16'd17;
  localparam logic [NORM_W-1:0] NORM_ONE     = 15'd16384;
  localparam logic [31:0]       DIST_MISS    = 32'hFFFF_0000;
  localparam logic [31:0]       DIST_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [31:0]       DIST_NEG_SAT = 32'h8000_0000;

  typedef struct packed {
    logic              req_type;
    logic [1:0]        vertex_slot;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } out_res_t;

  typedef struct packed {
    logic [NORM_W-1:0] mag_x;
    logic [NORM_W-1:0] mag_y;
    logic [NORM_W-1:0] mag_z;
    logic              neg_x;
    logic              neg_y;
    logic              neg_z;
  } nrm_snap_t;

endpackage

/* hw/rtl/rti_fifo.sv */
// short request queue between the front and the back
module rti_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign empty      = (cnt_r == '0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/rti_front.sv */
// front end: vertex store, request classification and face normal unit
module rti_front #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rti_pkg::in_req_t                in_req,
  output logic                            q_push_valid,
  input  logic                            q_push_ready,
  output logic [6*COORD_WIDTH-1:0]        q_push_data,
  input  logic                            q_empty,
  output logic signed [COORD_WIDTH-1:0]   snap_v0 [3],
  output logic signed [COORD_WIDTH:0]     snap_ea [3],
  output logic signed [COORD_WIDTH:0]     snap_eb [3],
  output logic signed [2*COORD_WIDTH+2:0] snap_cr [3],
  output rti_pkg::nrm_snap_t              snap_nrm
);
  import rti_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int D   = W + 1;
  localparam int CRW = 2 * D + 1;
  localparam int PRW = 2 * D;

  typedef enum logic [7:0] {
    N_IDLE   = 8'b0000_0001,
    N_CROSS  = 8'b0000_0010,
    N_DIFF   = 8'b0000_0100,
    N_NORM   = 8'b0000_1000,
    N_SQ     = 8'b0001_0000,
    N_SQRT   = 8'b0010_0000,
    N_DIV    = 8'b0100_0000,
    N_COMMIT = 8'b1000_0000
  } nst_t;

  nst_t                 st_r, st_nxt;
  logic [2:0]           written_r;
  logic                 dirty_r;
  logic signed [W-1:0]  vtx_r [3][3];
  logic signed [D-1:0]  ua [3], ub [3];
  logic signed [PRW-1:0] pp_r [6];
  logic signed [CRW-1:0] crd [3];
  logic signed [CRW-1:0] cr_r [3];
  logic [CRW-1:0]       mag_r [3];
  logic [CRW-1:0]       top;
  logic [2:0]           crneg_r;
  logic [63:0]          acc_r, res_r, sbit_r, sqt;
  logic [59:0]          sq;
  logic [1:0]           idx_r, nidx;
  logic [3:0]           k_r;
  logic [46:0]          rem_r, dsh;
  logic [15:0]          q_r, q_new;
  logic                 dge;
  logic [NORM_W-1:0]    nmag_r [3];
  logic signed [W-1:0]  sv0_r [3];
  logic signed [D-1:0]  sea_r [3], seb_r [3];
  logic signed [CRW-1:0] scr_r [3];
  nrm_snap_t            snrm_r;
  logic                 is_ray, all_w, idle, ld_acc, norm_ok;

  assign is_ray = (in_req.req_type == REQ_RAY);
  assign all_w  = &written_r;
  assign idle   = (st_r == N_IDLE);
  assign in_ready = idle & (!is_ray | !all_w | (!dirty_r & q_push_ready));
  assign q_push_valid = in_valid & idle & is_ray & all_w & !dirty_r;
  assign q_push_data = {W'(in_req.origin_x), W'(in_req.origin_y), W'(in_req.origin_z),
                        W'(in_req.dir_x), W'(in_req.dir_y), W'(in_req.dir_z)};
  assign ld_acc = in_valid & in_ready & !is_ray & (in_req.vertex_slot != 2'd3);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ua[i]  = D'(vtx_r[1][i]) - D'(vtx_r[0][i]);
      ub[i]  = D'(vtx_r[2][i]) - D'(vtx_r[0][i]);
      crd[i] = CRW'(pp_r[2*i]) - CRW'(pp_r[2*i+1]);
    end
    top     = mag_r[0] | mag_r[1] | mag_r[2];
    norm_ok = (top[CRW-1:30] == '0) & top[29];
    sq      = mag_r[idx_r][29:0] * mag_r[idx_r][29:0];
    sqt     = res_r + sbit_r;
    dsh     = 47'(res_r[30:0]) << k_r;
    dge     = (rem_r >= dsh);
    q_new   = q_r | (dge ? (16'd1 << k_r) : 16'd0);
    nidx    = idx_r + 2'd1;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      N_IDLE:   if (in_valid & is_ray & all_w & dirty_r) st_nxt = N_CROSS;
      N_CROSS:  st_nxt = N_DIFF;
      N_DIFF:   st_nxt = N_NORM;
      N_NORM: begin
        if (top == '0) st_nxt = N_COMMIT;
        else if (norm_ok) st_nxt = N_SQ;
      end
      N_SQ:     if (idx_r == 2'd2) st_nxt = N_SQRT;
      N_SQRT:   if (sbit_r == 64'd1) st_nxt = N_DIV;
      N_DIV:    if ((k_r == 4'd0) && (idx_r == 2'd2)) st_nxt = N_COMMIT;
      N_COMMIT: if (q_empty) st_nxt = N_IDLE;
      default:  st_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= N_IDLE;
      written_r <= '0;
      dirty_r   <= 1'b1;
    end else begin
      st_r <= st_nxt;
      if (ld_acc) begin
        written_r[in_req.vertex_slot] <= 1'b1;
        dirty_r <= 1'b1;
      end else if ((st_r == N_COMMIT) && q_empty) begin
        dirty_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_acc) begin
      vtx_r[in_req.vertex_slot][0] <= W'(in_req.vertex_x);
      vtx_r[in_req.vertex_slot][1] <= W'(in_req.vertex_y);
      vtx_r[in_req.vertex_slot][2] <= W'(in_req.vertex_z);
    end
    unique case (st_r)
      N_IDLE: begin
      end
      N_CROSS: begin
        pp_r[0] <= ua[1] * ub[2];
        pp_r[1] <= ua[2] * ub[1];
        pp_r[2] <= ua[2] * ub[0];
        pp_r[3] <= ua[0] * ub[2];
        pp_r[4] <= ua[0] * ub[1];
        pp_r[5] <= ua[1] * ub[0];
      end
      N_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          cr_r[i]    <= crd[i];
          crneg_r[i] <= crd[i][CRW-1];
          mag_r[i]   <= crd[i][CRW-1] ? CRW'(-crd[i]) : CRW'(crd[i]);
          nmag_r[i]  <= '0;
        end
        idx_r <= '0;
        acc_r <= '0;
      end
      N_NORM: begin
        if (top != '0 && !norm_ok) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= (top[CRW-1:30] != '0) ? (mag_r[i] >> 1) : (mag_r[i] << 1);
          end
        end
      end
      N_SQ: begin
        acc_r  <= acc_r + 64'(sq);
        idx_r  <= (idx_r == 2'd2) ? 2'd0 : nidx;
        res_r  <= '0;
        sbit_r <= 64'd1 << 62;
      end
      N_SQRT: begin
        if (acc_r >= sqt) begin
          acc_r <= acc_r - sqt;
          res_r <= (res_r >> 1) + sbit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
        rem_r  <= 47'(mag_r[0][29:0]) << 14;
        k_r    <= 4'd15;
        q_r    <= '0;
      end
      N_DIV: begin
        if (k_r == 4'd0) begin
          nmag_r[idx_r] <= (q_new > 16'(NORM_ONE)) ? NORM_ONE : q_new[NORM_W-1:0];
          if (idx_r != 2'd2) begin
            idx_r <= nidx;
            rem_r <= 47'(mag_r[nidx][29:0]) << 14;
          end
          k_r <= 4'd15;
          q_r <= '0;
        end else begin
          if (dge) rem_r <= rem_r - dsh;
          q_r <= q_new;
          k_r <= k_r - 4'd1;
        end
      end
      N_COMMIT: begin
        if (q_empty) begin
          for (int i = 0; i < 3; i++) begin
            sv0_r[i] <= vtx_r[0][i];
            sea_r[i] <= -ua[i];
            seb_r[i] <= -ub[i];
            scr_r[i] <= cr_r[i];
          end
          snrm_r <= '{mag_x: nmag_r[0], mag_y: nmag_r[1], mag_z: nmag_r[2],
                      neg_x: crneg_r[0], neg_y: crneg_r[1], neg_z: crneg_r[2]};
        end
      end
      default: begin
      end
    endcase
  end

  assign snap_v0  = sv0_r;
  assign snap_ea  = sea_r;
  assign snap_eb  = seb_r;
  assign snap_cr  = scr_r;
  assign snap_nrm = snrm_r;

endmodule

/* hw/rtl/rti_back.sv */
// back end: determinant pipeline, barycentric test and pipelined divider
module rti_back #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_pop_valid,
  output logic                            q_pop_ready,
  input  logic [6*COORD_WIDTH-1:0]        q_data,
  input  logic signed [COORD_WIDTH-1:0]   snap_v0 [3],
  input  logic signed [COORD_WIDTH:0]     snap_ea [3],
  input  logic signed [COORD_WIDTH:0]     snap_eb [3],
  input  logic signed [2*COORD_WIDTH+2:0] snap_cr [3],
  input  rti_pkg::nrm_snap_t              snap_nrm,
  input  logic [15:0]                     tol,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rti_pkg::out_res_t               out_res
);
  import rti_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int D   = W + 1;
  localparam int CRW = 2 * D + 1;
  localparam int LW  = D + 1;
  localparam int PW  = D + LW + 1;
  localparam int SW  = PW + 2;
  localparam int DW  = 3 * D + 3;
  localparam int TH  = DW / 2;
  localparam int TW  = DW + 16;
  localparam int CW  = DW + 27;
  localparam int QW  = DW + 32;
  localparam int NDIV = 31;

  typedef struct packed {
    logic hit;
    logic sat;
    logic neg;
    logic nflip;
  } dflg_t;

  logic        en;
  logic [8:0]  vld_r;
  logic        out_valid_r;
  out_res_t    out_res_r;

  logic signed [D-1:0]   dir1_r [3], rel1_r [3], ea1_r [3], eb1_r [3];
  logic signed [CRW-1:0] cr1_r [3];
  nrm_snap_t             nrm_r [9];

  logic signed [2*D-1:0] pm2_r [12];
  logic signed [PW-1:0]  dl2_r [3], dh2_r [3], tl2_r [3], th2_r [3];
  logic signed [D-1:0]   rel2_r [3], rel3_r [3];

  logic signed [CRW-1:0] m3_r [3], n3_r [3];
  logic signed [SW-1:0]  dl3_r, dh3_r, tl3_r, th3_r;

  logic signed [DW-1:0]  den4_r, tn4_r;
  logic signed [PW-1:0]  bl4_r [3], bh4_r [3], gl4_r [3], gh4_r [3];

  logic                  dneg_r [5:9], dzero_r [5:9];
  logic [DW-1:0]         dena_r [5:9];
  logic signed [DW-1:0]  tna_r [5:8];
  logic signed [SW-1:0]  bl5_r, bh5_r, gl5_r, gh5_r;

  logic signed [DW-1:0]  bn6_r, gn6_r;
  logic [16+TH-1:0]      tl6_r;
  logic [16+DW-TH-1:0]   th6_r;

  logic signed [DW-1:0]  b7_r, g7_r;
  logic [TW-1:0]         tden7_r;

  logic signed [CW-1:0]  b24_8_r, g24_8_r, b24t8_r, g24t8_r, bg8_r, lim8_r;
  logic [DW-1:0]         tabs8_r;

  logic [QW-1:0]         rem9, rem9_r;
  dflg_t                 flg9_r;

  logic [QW-1:0]         drem_r [NDIV];
  logic [30:0]           dq_r [NDIV];
  dflg_t                 dflg_r [NDIV];
  logic [DW-1:0]         dden_r [NDIV];
  nrm_snap_t             dnrm_r [NDIV];
  logic [NDIV-1:0]       dvld_r;

  assign en          = !out_valid_r | out_ready;
  assign q_pop_ready = en;
  assign out_valid   = out_valid_r;
  assign out_res     = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      dvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[7:0], q_pop_valid};
      dvld_r      <= {dvld_r[NDIV-2:0], vld_r[8]};
      out_valid_r <= dvld_r[NDIV-1];
    end
  end

  // front stages: operand set-up and determinants
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dir1_r[i] <= D'($signed(q_data[(2-i)*W +: W]));
        rel1_r[i] <= D'(snap_v0[i]) - D'($signed(q_data[(5-i)*W +: W]));
        ea1_r[i]  <= snap_ea[i];
        eb1_r[i]  <= snap_eb[i];
        cr1_r[i]  <= snap_cr[i];
      end
      nrm_r[0] <= snap_nrm;
      for (int s = 1; s < 9; s++) nrm_r[s] <= nrm_r[s-1];

      pm2_r[0]  <= eb1_r[1] * dir1_r[2];
      pm2_r[1]  <= eb1_r[2] * dir1_r[1];
      pm2_r[2]  <= eb1_r[2] * dir1_r[0];
      pm2_r[3]  <= eb1_r[0] * dir1_r[2];
      pm2_r[4]  <= eb1_r[0] * dir1_r[1];
      pm2_r[5]  <= eb1_r[1] * dir1_r[0];
      pm2_r[6]  <= dir1_r[1] * ea1_r[2];
      pm2_r[7]  <= dir1_r[2] * ea1_r[1];
      pm2_r[8]  <= dir1_r[2] * ea1_r[0];
      pm2_r[9]  <= dir1_r[0] * ea1_r[2];
      pm2_r[10] <= dir1_r[0] * ea1_r[1];
      pm2_r[11] <= dir1_r[1] * ea1_r[0];
      for (int i = 0; i < 3; i++) begin
        dl2_r[i]  <= dir1_r[i] * $signed({1'b0, cr1_r[i][LW-1:0]});
        dh2_r[i]  <= PW'(dir1_r[i] * $signed(cr1_r[i][CRW-1:LW]));
        tl2_r[i]  <= rel1_r[i] * $signed({1'b0, cr1_r[i][LW-1:0]});
        th2_r[i]  <= PW'(rel1_r[i] * $signed(cr1_r[i][CRW-1:LW]));
        rel2_r[i] <= rel1_r[i];
      end

      for (int i = 0; i < 3; i++) begin
        m3_r[i]   <= CRW'(pm2_r[2*i]) - CRW'(pm2_r[2*i+1]);
        n3_r[i]   <= CRW'(pm2_r[6+2*i]) - CRW'(pm2_r[7+2*i]);
        rel3_r[i] <= rel2_r[i];
      end
      dl3_r <= SW'(dl2_r[0]) + SW'(dl2_r[1]) + SW'(dl2_r[2]);
      dh3_r <= SW'(dh2_r[0]) + SW'(dh2_r[1]) + SW'(dh2_r[2]);
      tl3_r <= SW'(tl2_r[0]) + SW'(tl2_r[1]) + SW'(tl2_r[2]);
      th3_r <= SW'(th2_r[0]) + SW'(th2_r[1]) + SW'(th2_r[2]);

      den4_r <= (DW'(dh3_r) <<< LW) + DW'(dl3_r);
      tn4_r  <= (DW'(th3_r) <<< LW) + DW'(tl3_r);
      for (int i = 0; i < 3; i++) begin
        bl4_r[i] <= rel3_r[i] * $signed({1'b0, m3_r[i][LW-1:0]});
        bh4_r[i] <= PW'(rel3_r[i] * $signed(m3_r[i][CRW-1:LW]));
        gl4_r[i] <= rel3_r[i] * $signed({1'b0, n3_r[i][LW-1:0]});
        gh4_r[i] <= PW'(rel3_r[i] * $signed(n3_r[i][CRW-1:LW]));
      end

      dneg_r[5]  <= den4_r[DW-1];
      dzero_r[5] <= (den4_r == '0);
      dena_r[5]  <= den4_r[DW-1] ? DW'(-den4_r) : DW'(den4_r);
      tna_r[5]   <= den4_r[DW-1] ? -tn4_r : tn4_r;
      bl5_r <= SW'(bl4_r[0]) + SW'(bl4_r[1]) + SW'(bl4_r[2]);
      bh5_r <= SW'(bh4_r[0]) + SW'(bh4_r[1]) + SW'(bh4_r[2]);
      gl5_r <= SW'(gl4_r[0]) + SW'(gl4_r[1]) + SW'(gl4_r[2]);
      gh5_r <= SW'(gh4_r[0]) + SW'(gh4_r[1]) + SW'(gh4_r[2]);

      for (int s = 6; s < 10; s++) begin
        dneg_r[s]  <= dneg_r[s-1];
        dzero_r[s] <= dzero_r[s-1];
        dena_r[s]  <= dena_r[s-1];
      end
      for (int s = 6; s < 9; s++) tna_r[s] <= tna_r[s-1];

      bn6_r <= (DW'(bh5_r) <<< LW) + DW'(bl5_r);
      gn6_r <= (DW'(gh5_r) <<< LW) + DW'(gl5_r);
      tl6_r <= tol * dena_r[5][TH-1:0];
      th6_r <= tol * dena_r[5][DW-1:TH];

      b7_r    <= dneg_r[6] ? -bn6_r : bn6_r;
      g7_r    <= dneg_r[6] ? -gn6_r : gn6_r;
      tden7_r <= (TW'(th6_r) << TH) + TW'(tl6_r);

      b24_8_r <= CW'(b7_r) <<< 24;
      g24_8_r <= CW'(g7_r) <<< 24;
      b24t8_r <= (CW'(b7_r) <<< 24) + $signed(CW'(tden7_r));
      g24t8_r <= (CW'(g7_r) <<< 24) + $signed(CW'(tden7_r));
      bg8_r   <= (CW'(b7_r) <<< 24) + (CW'(g7_r) <<< 24);
      lim8_r  <= $signed(CW'(dena_r[7]) << 24) + $signed(CW'(tden7_r));
      tabs8_r <= tna_r[7][DW-1] ? DW'(-tna_r[7]) : DW'(tna_r[7]);

      rem9_r       <= rem9;
      flg9_r.hit   <= !dzero_r[8] & !b24t8_r[CW-1] & !g24t8_r[CW-1] &
                      (b24_8_r <= lim8_r) & (g24_8_r <= lim8_r) & (bg8_r <= lim8_r);
      flg9_r.sat   <= (rem9 >= (QW'(dena_r[8]) << 31));
      flg9_r.neg   <= tna_r[8][DW-1];
      flg9_r.nflip <= !dneg_r[8] & !dzero_r[8];
    end
  end

  assign rem9 = QW'(tabs8_r) << 16;

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [QW-1:0] rin, dsh;
    logic [30:0]   qin;
    dflg_t         fin;
    logic [DW-1:0] din;
    nrm_snap_t     nin;
    if (j == 0) begin : g_first
      assign rin = rem9_r;
      assign qin = '0;
      assign fin = flg9_r;
      assign din = dena_r[9];
      assign nin = nrm_r[8];
    end else begin : g_next
      assign rin = drem_r[j-1];
      assign qin = dq_r[j-1];
      assign fin = dflg_r[j-1];
      assign din = dden_r[j-1];
      assign nin = dnrm_r[j-1];
    end
    assign dsh = QW'(din) << (30 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[j] <= (rin >= dsh) ? rin - dsh : rin;
        dq_r[j]   <= qin | ((rin >= dsh) ? (31'd1 << (30 - j)) : 31'd0);
        dflg_r[j] <= fin;
        dden_r[j] <= din;
        dnrm_r[j] <= nin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r.hit <= dflg_r[NDIV-1].hit;
      priority if (!dflg_r[NDIV-1].hit) begin
        out_res_r.distance <= DIST_MISS;
      end else if (dflg_r[NDIV-1].sat) begin
        out_res_r.distance <= dflg_r[NDIV-1].neg ? DIST_NEG_SAT : DIST_POS_SAT;
      end else begin
        out_res_r.distance <= dflg_r[NDIV-1].neg ? -{1'b0, dq_r[NDIV-1]}
                                                 : {1'b0, dq_r[NDIV-1]};
      end
      out_res_r.normal_x <= (dnrm_r[NDIV-1].neg_x ^ dflg_r[NDIV-1].nflip)
                            ? -{1'b0, dnrm_r[NDIV-1].mag_x} : {1'b0, dnrm_r[NDIV-1].mag_x};
      out_res_r.normal_y <= (dnrm_r[NDIV-1].neg_y ^ dflg_r[NDIV-1].nflip)
                            ? -{1'b0, dnrm_r[NDIV-1].mag_y} : {1'b0, dnrm_r[NDIV-1].mag_y};
      out_res_r.normal_z <= (dnrm_r[NDIV-1].neg_z ^ dflg_r[NDIV-1].nflip)
                            ? -{1'b0, dnrm_r[NDIV-1].mag_z} : {1'b0, dnrm_r[NDIV-1].mag_z};
    end
  end

  a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.hit |-> out_res_r.distance == DIST_MISS)
    else $error("miss without miss distance");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(dvld_r))
    else $error("pipeline moved while stalled");

  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_valid && q_pop_ready |=> vld_r[0])
    else $error("popped request lost");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] |-> nrm_r[8].mag_x <= NORM_ONE && nrm_r[8].mag_y <= NORM_ONE &&
                 nrm_r[8].mag_z <= NORM_ONE)
    else $error("normal magnitude out of range");

endmodule

/* hw/rtl/ray_triangle_intersect.sv */
// ray / triangle intersection top level
// pipeline: an accepted ray request goes from the queue pop through 9 arithmetic
//   stages, 31 divider stages and the output register to out_valid; one ray per
//   cycle sustained while out_ready does not stall it; after a vertex load to slot
//   0, 1 or 2 the next ray waits for the face normal unit (normalising shifts, 32
//   root steps, 48 divide steps) plus any wait for the queue to drain
// reset: synchronous active low; clears handshakes, vertex written flags and
//   sets the tolerance to 17; vertex values are undefined until loaded
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rti_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output rti_pkg::out_res_t out_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import rti_pkg::*;

  localparam int W = COORD_WIDTH;

  logic                   push_valid, push_ready, pop_valid, pop_ready, q_empty;
  logic [6*W-1:0]         push_data, pop_data;
  logic signed [W-1:0]    snap_v0 [3];
  logic signed [W:0]      snap_ea [3], snap_eb [3];
  logic signed [2*W+2:0]  snap_cr [3];
  nrm_snap_t              snap_nrm;
  logic [15:0]            tol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  rti_front #(.COORD_WIDTH(W)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req,
    .q_push_valid(push_valid), .q_push_ready(push_ready), .q_push_data(push_data),
    .q_empty, .snap_v0, .snap_ea, .snap_eb, .snap_cr, .snap_nrm
  );

  rti_fifo #(.WIDTH(6 * W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst_n,
    .push_valid, .push_ready, .push_data,
    .pop_valid, .pop_ready, .pop_data,
    .empty(q_empty)
  );

  rti_back #(.COORD_WIDTH(W)) u_back (
    .clk, .rst_n,
    .q_pop_valid(pop_valid), .q_pop_ready(pop_ready), .q_data(pop_data),
    .snap_v0, .snap_ea, .snap_eb, .snap_cr, .snap_nrm,
    .tol(tol_r), .out_valid, .out_ready, .out_res
  );

endmodule

/* dv/testbench.sv */
// testbench for the ray / triangle intersection block: directed table, then checked random
`timescale 1ns / 1ps

module testbench;
  import rti_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef wide_t vec3_t [3];

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_res_t res;
  } row_t;

  localparam int          LIMIT     = 900000;
  localparam int          DRAIN     = 250;
  localparam logic [31:0] ONE       = 32'h0001_0000;
  localparam logic [31:0] QUARTER   = 32'h0000_4000;
  localparam int          N_ITEMS   = 1450;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_res;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [15:0] cfg_data = '0;

  logic signed [31:0] tri_vtx [3][3];
  bit          vtx_loaded [3];
  logic [15:0] tol_q;
  out_res_t    pending_hits [$];
  row_t        rows [$];
  int          cycles = 0;
  int          mismatches = 0;
  int          sent = 0;
  bit          hold_req = 1'b0;

  ray_triangle_intersect dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(out_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic wide_t det3(vec3_t a, vec3_t b, vec3_t c);
    wide_t m0, m1, m2;
    m0 = b[1] * c[2] - b[2] * c[1];
    m1 = b[0] * c[2] - b[2] * c[0];
    m2 = b[0] * c[1] - b[1] * c[0];
    return a[0] * m0 - a[1] * m1 + a[2] * m2;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned s);
    longint unsigned res, cand;
    res = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if (cand * cand <= s) res = cand;
    end
    return res;
  endfunction

  // returns 1 when the request gives a result
  function automatic bit intersect_ray(in_req_t r, output out_res_t o);
    vec3_t org, dirv, ea, eb, rel, ua, ub, cr;
    wide_t den, tnum, bnum, gnum, tolden, lim, b24, g24, dot, tolw, q;
    logic [255:0] mag [3];
    logic [255:0] top, s;
    longint unsigned comp [3];
    longint unsigned sumsq, len, v;
    int nb;
    bit hit;
    o = '0;
    if (r.req_type == REQ_LOAD) begin
      if (r.vertex_slot < 3) begin
        tri_vtx[r.vertex_slot][0] = r.vertex_x;
        tri_vtx[r.vertex_slot][1] = r.vertex_y;
        tri_vtx[r.vertex_slot][2] = r.vertex_z;
        vtx_loaded[r.vertex_slot] = 1'b1;
      end
      return 1'b0;
    end
    if (!(vtx_loaded[0] && vtx_loaded[1] && vtx_loaded[2])) return 1'b0;
    org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
    dirv[0] = r.dir_x;   dirv[1] = r.dir_y;   dirv[2] = r.dir_z;
    for (int i = 0; i < 3; i++) begin
      ea[i]  = wide_t'(tri_vtx[0][i]) - wide_t'(tri_vtx[1][i]);
      eb[i]  = wide_t'(tri_vtx[0][i]) - wide_t'(tri_vtx[2][i]);
      rel[i] = wide_t'(tri_vtx[0][i]) - org[i];
      ua[i]  = -ea[i];
      ub[i]  = -eb[i];
    end
    den  = det3(dirv, ea, eb);
    tnum = det3(rel, ea, eb);
    bnum = det3(dirv, rel, eb);
    gnum = det3(dirv, ea, rel);
    o.distance = DIST_MISS;
    hit = (den != 0);
    if (hit) begin
      if (den < 0) begin
        den = -den; tnum = -tnum; bnum = -bnum; gnum = -gnum;
      end
      tolw   = {240'd0, tol_q};
      tolden = tolw * den;
      lim    = (wide_t'(1) <<< 24) * den + tolden;
      b24    = bnum <<< 24;
      g24    = gnum <<< 24;
      hit = (b24 + tolden >= 0) && (b24 <= lim) && (g24 + tolden >= 0) &&
            (g24 <= lim) && (b24 + g24 <= lim);
      if (hit) begin
        q = ((tnum < 0) ? -tnum : tnum) <<< 16;
        if (q >= (den <<< 31)) o.distance = (tnum < 0) ? DIST_NEG_SAT : DIST_POS_SAT;
        else begin
          q = q / den;
          o.distance = (tnum < 0) ? -q[31:0] : q[31:0];
        end
      end
    end
    o.hit = hit;
    cr[0] = ua[1] * ub[2] - ua[2] * ub[1];
    cr[1] = ua[2] * ub[0] - ua[0] * ub[2];
    cr[2] = ua[0] * ub[1] - ua[1] * ub[0];
    dot = cr[0] * dirv[0] + cr[1] * dirv[1] + cr[2] * dirv[2];
    if (dot > 0) for (int i = 0; i < 3; i++) cr[i] = -cr[i];
    top = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (cr[i] < 0) ? -cr[i] : cr[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) return 1'b1;
    nb = 0;
    for (int i = 0; i < 256; i++) if (top[i]) nb = i + 1;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      s = (nb > 30) ? (mag[i] >> (nb - 30)) : (mag[i] << (30 - nb));
      comp[i] = s[63:0];
      sumsq += comp[i] * comp[i];
    end
    len = floor_root(sumsq);
    for (int i = 0; i < 3; i++) begin
      v = (comp[i] * 16384) / len;
      if (v > 16384) v = 16384;
      if (cr[i] < 0) v = -v;
      case (i)
        0: o.normal_x = v[15:0];
        1: o.normal_y = v[15:0];
        default: o.normal_z = v[15:0];
      endcase
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_res);
      end else begin
        want = pending_hits.pop_front();
        if (out_res.hit !== want.hit || out_res.distance !== want.distance ||
            out_res.normal_x !== want.normal_x || out_res.normal_y !== want.normal_y ||
            out_res.normal_z !== want.normal_z) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, out_res);
        end
      end
    end
  end

  // result side: bursts of ready, short and occasional long gaps, one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 3);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic send(in_req_t r, bit typed, out_res_t typed_res);
    out_res_t o;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    if (intersect_ray(r, o)) pending_hits.insert(pending_hits.size(), typed ? typed_res : o);
    sent++;
    case ($urandom_range(0, 19))
      0:       gap = $urandom_range(10, 40);
      1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle_and_set_tol(logic [15:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tol_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_req_t load_req(logic [1:0] slot, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z);
    in_req_t r;
    r = '0;
    r.req_type = REQ_LOAD; r.vertex_slot = slot;
    r.vertex_x = x; r.vertex_y = y; r.vertex_z = z;
    return r;
  endfunction

  function automatic in_req_t ray_req(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                      logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    in_req_t r;
    r = '0;
    r.req_type = REQ_RAY;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  function automatic void add_row(in_req_t r, bit typed = 0, logic h = 0,
                                  logic [31:0] d = 0, logic [15:0] nx = 0,
                                  logic [15:0] ny = 0, logic [15:0] nz = 0);
    row_t w;
    w.req = r; w.typed = typed;
    w.res.hit = h; w.res.distance = d;
    w.res.normal_x = nx; w.res.normal_y = ny; w.res.normal_z = nz;
    rows.insert(rows.size(), w);
  endfunction

  function automatic logic [31:0] rnd_full();
    return $urandom();
  endfunction

  function automatic logic [31:0] rnd_small();
    return $urandom_range(0, 2 * 32'h0010_0000) - 32'h0010_0000;
  endfunction

  initial begin
    logic signed [31:0] tv [3][3];
    logic signed [31:0] org [3];
    logic signed [31:0] tgt [3];
    logic signed [31:0] dv [3];
    logic [1:0] order [3];
    in_req_t r;
    out_res_t none;
    int bw, gw, sh, n_rays, phase;
    logic [15:0] tols [4];

    none = '0;
    tol_q = TOL_RESET;
    foreach (vtx_loaded[i]) vtx_loaded[i] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // rays before the triangle is complete give nothing
    add_row(ray_req(0, 0, ONE, 0, 0, -ONE));
    add_row(load_req(0, 0, 0, 0));
    add_row(load_req(1, ONE, 0, 0));
    add_row(load_req(2, 0, ONE, 0));
    add_row(ray_req(QUARTER, QUARTER, ONE, 0, 0, -ONE), 1, 1, ONE, 0, 0, 16'd16384);
    add_row(ray_req(2 * ONE, 2 * ONE, ONE, 0, 0, -ONE), 1, 0, DIST_MISS, 0, 0, 16'd16384);
    add_row(ray_req(QUARTER, QUARTER, ONE, ONE, 0, 0), 1, 0, DIST_MISS, 0, 0, 16'd16384);
    add_row(ray_req(QUARTER, QUARTER, -ONE, 0, 0, ONE), 1, 1, ONE, 0, 0, -16'sd16384);
    add_row(ray_req(2 * QUARTER, 2 * QUARTER, ONE, 0, 0, -ONE));
    add_row(ray_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(ray_req(QUARTER, QUARTER, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF));
    add_row(load_req(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(ray_req(QUARTER, QUARTER, ONE, 0, 0, -ONE), 1, 1, ONE, 0, 0, 16'd16384);
    add_row(load_req(2, 2 * ONE, 0, 0));
    add_row(ray_req(QUARTER, 0, ONE, 0, 0, -ONE), 1, 0, DIST_MISS, 0, 0, 0);
    add_row(load_req(0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    add_row(load_req(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(load_req(2, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    add_row(ray_req(0, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    add_row(ray_req(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full()));
    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].res);

    tols[0] = 16'd0; tols[1] = 16'hFFFF; tols[2] = 16'($urandom_range(0, 65535));
    tols[3] = TOL_RESET;
    phase = 0;
    while (sent < N_ITEMS) begin
      if (sent >= 20 + phase * 360 && phase < 4) begin
        settle_and_set_tol(tols[phase]);
        phase++;
      end
      if (sent > 400 && sent < 420) hold_req = 1'b1;
      if ($urandom_range(0, 99) < 85) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            tv[i][j] = ($urandom_range(0, 9) == 0) ? rnd_full() : rnd_small();
        if ($urandom_range(0, 19) == 0) tv[2] = tv[1];
        order[0] = 0; order[1] = 1; order[2] = 2;
        order.shuffle();
        for (int i = 0; i < 3; i++)
          send(load_req(order[i], tv[order[i]][0], tv[order[i]][1], tv[order[i]][2]), 0, none);
        n_rays = $urandom_range(3, 20);
        for (int k = 0; k < n_rays; k++) begin
          case ($urandom_range(0, 9))
            0, 1: r = ray_req(rnd_small(), rnd_small(), rnd_small(),
                              rnd_small(), rnd_small(), rnd_small());
            2, 3: r = ray_req(rnd_full(), rnd_full(), rnd_full(),
                              rnd_full(), rnd_full(), rnd_full());
            default: begin
              bw = $urandom_range(0, 256);
              gw = $urandom_range(0, 256 - bw);
              if ($urandom_range(0, 3) == 0) begin
                bw += $urandom_range(0, 4) - 2;
                gw += $urandom_range(0, 4) - 2;
              end
              sh = $urandom_range(0, 4);
              for (int j = 0; j < 3; j++) begin
                tgt[j] = 32'(tv[0][j] + ((longint'(tv[1][j] - tv[0][j]) * bw +
                                          longint'(tv[2][j] - tv[0][j]) * gw) / 256));
                org[j] = rnd_small();
                dv[j]  = (tgt[j] - org[j]) >>> sh;
              end
              r = ray_req(org[0], org[1], org[2], dv[0], dv[1], dv[2]);
            end
          endcase
          send(r, 0, none);
        end
      end else begin
        r = ray_req(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full());
        r.req_type    = 1'($urandom_range(0, 1));
        r.vertex_slot = 2'($urandom_range(0, 3));
        r.vertex_x = rnd_full(); r.vertex_y = rnd_full(); r.vertex_z = rnd_full();
        send(r, 0, none);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rti_pkg.sv
hw/rtl/rti_fifo.sv
hw/rtl/rti_front.sv
hw/rtl/rti_back.sv
hw/rtl/ray_triangle_intersect.sv
dv/testbench.sv
